@@ hdl/asma_pkg.sv @@
// shared types, sizes and constants for the scanned adc moving average block
// no dependencies; imported by every module in hdl/
package asma_pkg;

  // sizes
  localparam int NUM_SLOTS   = 8;
  localparam int WINDOW      = 8;
  localparam int SAMPLE_BITS = 12;

  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int PTR_W     = $clog2(WINDOW);
  localparam int ADDR_W    = SLOT_W + PTR_W;
  localparam int MEM_DEPTH = NUM_SLOTS * WINDOW;
  localparam int SUM_W     = SAMPLE_BITS + PTR_W;
  localparam int CHAN_W    = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int ADC_PER_W = 16;
  localparam int BLK_PER_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADC_PERIOD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 1'd1;

  // register reset values
  localparam logic [ADC_PER_W-1:0] ADC_PERIOD_RST   = 16'd2;
  localparam logic [BLK_PER_W-1:0] BLINK_PERIOD_RST = 8'd100;

  // largest window sum
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_BITS) - 1));

  // scan order: slot to analog channel
  localparam logic [CHAN_W-1:0] SLOT_CHANNEL [16] = '{
    4'd0, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
    4'd2, 4'd3, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  function automatic logic [CHAN_W-1:0] chan_of(input logic [SLOT_W-1:0] slot);
    logic [3:0] idx;
    idx = 4'(slot);
    return SLOT_CHANNEL[idx];
  endfunction

  // one tick after the counters, waiting for the store read
  typedef struct packed {
    logic                   taken;
    logic [SLOT_W-1:0]      slot;
    logic [PTR_W-1:0]       ptr;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CHAN_W-1:0]      next_ch;
    logic                   level;
    logic                   pulse;
  } tick_t;

  // finished result word
  typedef struct packed {
    logic                   taken;
    logic [CHAN_W-1:0]      done;
    logic [SAMPLE_BITS-1:0] avg;
    logic [CHAN_W-1:0]      next_ch;
    logic                   level;
    logic                   pulse;
  } result_t;

endpackage

@@ hdl/adc_scan_moving_average_top.sv @@
// top level of the scanned adc moving average: handshakes and output register
// depends on asma_pkg, asma_sched and asma_window
// an accepted word passes through the first pipeline register, then the output register
// throughput: one word per cycle while the output is not stalled; the store read for a tick is issued as it is taken
// a stalled output holds the whole two-stage pipeline, input ready falls with it
// reset (synchronous, active high) clears counters, pointers, sums and store flags
// at once; adc_period resets to 2 and blink_period to 100
module adc_scan_moving_average_top
  import asma_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   sample_taken,
  output logic [CHAN_W-1:0]      channel_done,
  output logic [SAMPLE_BITS-1:0] channel_average,
  output logic [CHAN_W-1:0]      next_channel,
  output logic                   status_level,
  output logic                   blink_pulse,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic              adv;
  logic [ADDR_W-1:0] rd_addr;
  logic              s1_valid;
  tick_t             s1;
  result_t           res;

  // pipeline moves whenever the output register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  asma_sched u_sched (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .adc_sample (adc_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rd_addr    (rd_addr),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  asma_window u_window (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1       (s1),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      sample_taken    <= res.taken;
      channel_done    <= res.done;
      channel_average <= res.avg;
      next_channel    <= res.next_ch;
      status_level    <= res.level;
      blink_pulse     <= res.pulse;
    end
  end

endmodule

@@ hdl/asma_sched.sv @@
// tick scheduler: config registers, blink and scan counters, ring pointers
// depends on asma_pkg; feeds the first pipeline register and the store read address
module asma_sched
  import asma_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic [ADDR_W-1:0]      rd_addr,
  output logic                   s1_valid,
  output tick_t                  s1
);

  logic [ADC_PER_W-1:0] adc_period;
  logic [BLK_PER_W-1:0] blink_period;
  logic [BLK_PER_W-1:0] blink_count;
  logic [ADC_PER_W-1:0] scan_count;
  logic [SLOT_W-1:0]    scan_slot;
  logic [PTR_W-1:0]     ring_ptr [NUM_SLOTS];
  logic                 level_bit;

  logic [BLK_PER_W-1:0] blink_inc;
  logic [ADC_PER_W-1:0] scan_inc;
  logic                 blink_hit;
  logic                 scan_hit;
  logic [PTR_W-1:0]     cur_ptr;
  logic [PTR_W-1:0]     ptr_next;
  logic [SLOT_W-1:0]    slot_wrap;
  logic [SLOT_W-1:0]    scan_slot_next;
  logic                 accept;

  assign accept = adv && in_valid;

  // counter compares, counters wrap at their widths first
  assign blink_inc = blink_count + 1'b1;
  assign scan_inc  = scan_count + 1'b1;
  assign blink_hit = (blink_inc >= blink_period);
  assign scan_hit  = (scan_inc >= adc_period);

  // ring pointer advances before the write
  assign cur_ptr  = ring_ptr[scan_slot];
  assign ptr_next = (cur_ptr == PTR_W'(WINDOW - 1)) ? '0 : cur_ptr + 1'b1;

  assign slot_wrap      = (scan_slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : scan_slot + 1'b1;
  assign scan_slot_next = scan_hit ? slot_wrap : scan_slot;

  assign rd_addr = {scan_slot, ptr_next};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_period   <= ADC_PERIOD_RST;
      blink_period <= BLINK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADC_PERIOD:   adc_period   <= cfg_data[ADC_PER_W-1:0];
        REG_BLINK_PERIOD: blink_period <= cfg_data[BLK_PER_W-1:0];
        default: ;
      endcase
    end
  end

  // counters, scan position and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_count <= '0;
      scan_count  <= '0;
      scan_slot   <= '0;
      level_bit   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ring_ptr[i] <= '0;
      end
    end else if (accept) begin
      blink_count <= blink_hit ? '0 : blink_inc;
      scan_count  <= scan_hit ? '0 : scan_inc;
      level_bit   <= level_bit ^ blink_hit;
      scan_slot   <= scan_slot_next;
      if (scan_hit) begin
        ring_ptr[scan_slot] <= ptr_next;
      end
    end
  end

  // first pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.taken   <= scan_hit;
      s1.slot    <= scan_slot;
      s1.ptr     <= ptr_next;
      s1.sample  <= adc_sample;
      s1.next_ch <= chan_of(scan_slot_next);
      s1.level   <= level_bit ^ blink_hit;
      s1.pulse   <= blink_hit;
    end
  end

endmodule

@@ hdl/asma_window.sv @@
// sample store, per-slot running sums and the average of one slot
// depends on asma_pkg; read address comes from asma_sched as the tick enters the first pipeline register
module asma_window
  import asma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              s1_valid,
  input  tick_t             s1,
  output result_t           res
);

  logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]   entry_valid;
  logic [SUM_W-1:0]       slot_sum [NUM_SLOTS];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_valid;

  logic [ADDR_W-1:0]      wr_addr;
  logic                   wr_en;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_next;

  assign wr_addr = {s1.slot, s1.ptr};
  assign wr_en   = adv && s1_valid && s1.taken;

  // an entry never written reads as zero
  assign old_sample = rd_valid ? rd_data : '0;

  // drop the overwritten sample, add the new one
  assign sum_next = slot_sum[s1.slot] - SUM_W'(old_sample) + SUM_W'(s1.sample);

  // sample memory, registered read
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= s1.sample;
    end
  end

  // written flags and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_sum[i] <= '0;
      end
    end else begin
      if (adv) begin
        rd_valid <= entry_valid[rd_addr];
      end
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
        slot_sum[s1.slot]    <= sum_next;
      end
    end
  end

  // result word
  always_comb begin
    res.taken   = s1.taken;
    res.done    = s1.taken ? chan_of(s1.slot) : '0;
    res.avg     = s1.taken ? SAMPLE_BITS'(sum_next / SUM_W'(WINDOW)) : '0;
    res.next_ch = s1.next_ch;
    res.level   = s1.level;
    res.pulse   = s1.pulse;
  end

  // a written entry is marked for later reads
  assert property (@(posedge clk) disable iff (rst)
    wr_en |=> entry_valid[$past(wr_addr)])
    else $error("store entry not marked after write");

  // running sum stays within the window range
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (sum_next <= SUM_MAX))
    else $error("window sum out of range");

  // no sample means empty channel and average
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1.taken) |-> (res.done == '0 && res.avg == '0))
    else $error("result fields set without a sample");

endmodule
